FILE: rtl/particle_pool_update_unit_defines.svh
// Assertion macros for the particle pool update unit
`ifndef PARTICLE_POOL_UPDATE_UNIT_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PPU_ASSERT_IMPL(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("particle pool assertion failed");
`define PPU_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("particle pool forbidden condition");
`else
`define PPU_ASSERT_IMPL(lbl, prop)
`define PPU_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: rtl/ppu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppu_pkg;

    localparam int SLOTS_DEF = 64;

    localparam logic [16:0] INITIAL_LIFE_RST = 17'd65536;
    localparam logic [11:0] FADE_RATE_RST    = 12'd640;
    localparam logic [16:0] ALPHA_FULL       = 17'd65536;

    // ceil(2^27/10) and ceil(2^19/10): divide by ten for the value ranges used
    localparam logic [23:0] RECIP10_27 = 24'd13421773;
    localparam logic [15:0] RECIP10_19 = 16'd52429;

    localparam logic [1:0] OP_SPAWN = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;

    localparam logic CFG_INITIAL_LIFE = 1'b0;
    localparam logic CFG_FADE_RATE    = 1'b1;

    typedef struct packed {
        logic [16:0] life;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] vel_x;
        logic [23:0] vel_y;
        logic [16:0] alpha;
        logic [6:0]  gray;
    } rec_t;

    typedef struct packed {
        logic tick;
        logic load;
    } head_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/ppu_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ppu_cell (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         shift,
    input  wire ppu_pkg::rec_t d,
    output ppu_pkg::rec_t     q
);
    logic [16:0] life_reg;
    ppu_pkg::rec_t data_reg;

    // life is the live mark and must clear on reset; the rest is payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            life_reg <= '0;
        end
        else if (shift)
        begin
            life_reg <= d.life;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    always_comb
    begin
        q      = data_reg;
        q.life = life_reg;
    end
endmodule
`default_nettype wire

FILE: rtl/ppu_head.sv
`timescale 1ns / 1ps
`default_nettype none
module ppu_head (
    input  wire ppu_pkg::rec_t      rec_i,
    input  wire ppu_pkg::head_ctrl_t ctrl,
    input  wire ppu_pkg::rec_t      spawn_rec,
    input  wire logic [15:0]        dt,
    input  wire logic [19:0]        loss,
    output ppu_pkg::rec_t           rec_o
);
    logic [16:0]        life_new;
    logic signed [40:0] px_prod;
    logic signed [40:0] py_prod;
    logic signed [40:0] px_rnd;
    logic signed [40:0] py_rnd;
    logic [23:0]        px_step;
    logic [23:0]        py_step;

    always_comb
    begin
        life_new = (rec_i.life > {1'b0, dt}) ? rec_i.life - {1'b0, dt} : '0;
        px_prod  = $signed(rec_i.vel_x) * $signed({1'b0, dt});
        py_prod  = $signed(rec_i.vel_y) * $signed({1'b0, dt});
        // bias negatives so the shift truncates toward zero
        px_rnd   = px_prod + (px_prod[40] ? 41'sd65535 : 41'sd0);
        py_rnd   = py_prod + (py_prod[40] ? 41'sd65535 : 41'sd0);
        px_step  = px_rnd[39:16];
        py_step  = py_rnd[39:16];

        rec_o = rec_i;
        if (ctrl.load)
        begin
            rec_o = spawn_rec;
        end
        else if (ctrl.tick)
        begin
            rec_o.life = life_new;
            if (life_new != '0)
            begin
                rec_o.pos_x = rec_i.pos_x - px_step;
                rec_o.pos_y = rec_i.pos_y - py_step;
                rec_o.alpha = ({3'b0, rec_i.alpha} > loss) ?
                              17'(({3'b0, rec_i.alpha}) - loss) : '0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/particle_pool_update_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Each item walks the slot ring: tick and draw pass every slot once (draw waits while
// the output stalls), spawn passes it twice (scan, then load); an unused op goes
// straight to the final transfer. One item at a time: the input reopens with the
// final transfer offered. The slot ring rotates one slot per cycle past the single
// head update unit, except while a draw stalls on the output.
// Reset (async, active low): all slots dead, search pointer 0, defaults restored.
`include "particle_pool_update_unit_defines.svh"
module particle_pool_update_unit #(
    parameter int SLOTS = ppu_pkg::SLOTS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // delta_time[15:0] obj_x[39:16] obj_y[63:40] obj_vel_x[87:64]
    // obj_vel_y[111:88] offset_x[135:112] offset_y[159:136] jitter[166:160]
    // shade[173:167], zero pad to 176
    input  wire logic [175:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // slot[5:0] pos_x[29:6] pos_y[53:30] alpha[70:54] gray[77:71]
    // valid_res[78], zero pad to 80
    output logic [79:0]       m_axis_tdata,
    output logic              m_axis_tlast,
    // configuration
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [16:0]  cfg_data
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SPAWN = 3'd2;
    localparam logic [2:0] ST_TICK  = 3'd3;
    localparam logic [2:0] ST_DRAW  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]    state_reg;
    logic [IW-1:0] k_reg;
    logic [IW-1:0] start_reg;
    logic [IW-1:0] sel_reg;
    logic [IW-1:0] hi_reg;
    logic [IW-1:0] lo_reg;
    logic          hi_found_reg;
    logic          lo_found_reg;

    logic [16:0] initial_life_reg;
    logic [11:0] fade_reg;

    // item operands, held for the whole item
    logic [15:0] dt_reg;
    logic [23:0] objx_reg, objy_reg, offx_reg, offy_reg;
    logic [6:0]  shade_reg;
    logic        vxneg_reg, vyneg_reg, jneg_reg;
    logic [23:0] vxabs_reg, vyabs_reg;
    logic [14:0] jabs_reg;
    logic [47:0] vxprod_reg, vyprod_reg;
    logic [30:0] jprod_reg;
    logic [19:0] loss_reg;

    // pending result (held back to learn whether it is the last)
    logic        pend_valid_reg;
    logic [78:0] pend_reg;

    logic        out_valid_reg;
    logic [79:0] out_data_reg;
    logic        out_last_reg;

    logic          accept;
    logic          out_free;
    logic          out_load;
    logic          head_live;
    logic          stall;
    logic          shift;
    logic          at_end;
    logic [IW-1:0] sel_next;
    logic [6:0]    jd;
    logic [23:0]   jit;
    logic [23:0]   qx, qy;
    logic [23:0]   in_vx, in_vy;
    logic [6:0]    in_j;

    ppu_pkg::rec_t      ring_q [SLOTS];
    ppu_pkg::rec_t      head_out;
    ppu_pkg::rec_t      spawn_rec;
    ppu_pkg::head_ctrl_t head_ctrl;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign head_live     = (ring_q[0].life != '0);
    assign at_end        = (k_reg == IW'(SLOTS - 1));

    // a live slot can be taken only once the older pending one has a place
    assign stall = (state_reg == ST_DRAW) && head_live && pend_valid_reg && !out_free;
    assign shift = (state_reg == ST_SCAN) || (state_reg == ST_SPAWN) ||
                   (state_reg == ST_TICK) || ((state_reg == ST_DRAW) && !stall);

    // a new transfer goes into the output register
    assign out_load = ((state_reg == ST_DRAW) && shift && head_live && pend_valid_reg) ||
                      ((state_reg == ST_FIN) && out_free);

    assign in_vx = s_axis_tdata[87:64];
    assign in_vy = s_axis_tdata[111:88];
    assign in_j  = s_axis_tdata[166:160];
    assign jd    = (in_j < 7'd50) ? 7'd50 - in_j : in_j - 7'd50;

    // quotients by ten, sign restored
    always_comb
    begin
        qx  = {3'b0, vxprod_reg[47:27]};
        qy  = {3'b0, vyprod_reg[47:27]};
        qx  = vxneg_reg ? -qx : qx;
        qy  = vyneg_reg ? -qy : qy;
        jit = {12'b0, jprod_reg[30:19]};
        jit = jneg_reg ? -jit : jit;

        spawn_rec.life  = initial_life_reg;
        spawn_rec.pos_x = objx_reg + offx_reg + jit;
        spawn_rec.pos_y = objy_reg + offy_reg + jit;
        spawn_rec.vel_x = qx;
        spawn_rec.vel_y = qy;
        spawn_rec.alpha = ppu_pkg::ALPHA_FULL;
        spawn_rec.gray  = shade_reg;

        if (hi_found_reg)
        begin
            sel_next = hi_reg;
        end
        else if (lo_found_reg)
        begin
            sel_next = lo_reg;
        end
        else
        begin
            sel_next = '0;
        end

        // slot 0 passes the head before sel_reg is loaded, so it compares sel_next
        head_ctrl.tick = (state_reg == ST_TICK);
        head_ctrl.load = (state_reg == ST_SPAWN) &&
                         (k_reg == ((k_reg == '0) ? sel_next : sel_reg));
    end

    ppu_head u_head (
        .rec_i     (ring_q[0]),
        .ctrl      (head_ctrl),
        .spawn_rec (spawn_rec),
        .dt        (dt_reg),
        .loss      (loss_reg),
        .rec_o     (head_out)
    );

    // the ring: slot k sits in cell 0 after k shifts, the head writes cell SLOTS-1
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        if (i == SLOTS - 1)
        begin : g_tail
            ppu_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (head_out),
                .q     (ring_q[i])
            );
        end
        else
        begin : g_mid
            ppu_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (ring_q[i+1]),
                .q     (ring_q[i])
            );
        end
    end

    // operand capture and the divide-by-ten products
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dt_reg    <= s_axis_tdata[15:0];
            objx_reg  <= s_axis_tdata[39:16];
            objy_reg  <= s_axis_tdata[63:40];
            offx_reg  <= s_axis_tdata[135:112];
            offy_reg  <= s_axis_tdata[159:136];
            shade_reg <= s_axis_tdata[173:167];
            vxneg_reg <= in_vx[23];
            vyneg_reg <= in_vy[23];
            vxabs_reg <= in_vx[23] ? -in_vx : in_vx;
            vyabs_reg <= in_vy[23] ? -in_vy : in_vy;
            jneg_reg  <= (in_j < 7'd50);
            jabs_reg  <= {jd, 8'b0};
            loss_reg  <= 20'((28'(s_axis_tdata[15:0]) * 28'(fade_reg)) >> 8);
        end
        vxprod_reg <= 48'(vxabs_reg) * 48'(ppu_pkg::RECIP10_27);
        vyprod_reg <= 48'(vyabs_reg) * 48'(ppu_pkg::RECIP10_27);
        jprod_reg  <= 31'(jabs_reg) * 31'(ppu_pkg::RECIP10_19);
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SPAWN) && head_ctrl.load)
        begin
            pend_reg <= {1'b1, spawn_rec.gray, spawn_rec.alpha, spawn_rec.pos_y,
                         spawn_rec.pos_x, 6'(k_reg)};
        end
        else if ((state_reg == ST_DRAW) && shift && head_live)
        begin
            pend_reg <= {1'b1, ring_q[0].gray, ring_q[0].alpha, ring_q[0].pos_y,
                         ring_q[0].pos_x, 6'(k_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if ((state_reg == ST_DRAW) && shift && head_live && pend_valid_reg)
            begin
                out_data_reg <= {1'b0, pend_reg};
                out_last_reg <= 1'b0;
            end
            else if (state_reg == ST_FIN)
            begin
                out_data_reg <= pend_valid_reg ? {1'b0, pend_reg} : '0;
                out_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            k_reg            <= '0;
            start_reg        <= '0;
            sel_reg          <= '0;
            hi_reg           <= '0;
            lo_reg           <= '0;
            hi_found_reg     <= 1'b0;
            lo_found_reg     <= 1'b0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            initial_life_reg <= ppu_pkg::INITIAL_LIFE_RST;
            fade_reg         <= ppu_pkg::FADE_RATE_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ppu_pkg::CFG_INITIAL_LIFE: initial_life_reg <= cfg_data;
                    ppu_pkg::CFG_FADE_RATE:    fade_reg <= cfg_data[11:0];
                    default: ;
                endcase
            end

            if (shift)
            begin
                k_reg <= at_end ? '0 : k_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        k_reg        <= '0;
                        hi_found_reg <= 1'b0;
                        lo_found_reg <= 1'b0;
                        case (s_axis_tuser)
                            ppu_pkg::OP_SPAWN: state_reg <= ST_SCAN;
                            ppu_pkg::OP_TICK:  state_reg <= ST_TICK;
                            ppu_pkg::OP_DRAW:  state_reg <= ST_DRAW;
                            default:           state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (!head_live)
                    begin
                        if ((k_reg >= start_reg) && !hi_found_reg)
                        begin
                            hi_reg       <= k_reg;
                            hi_found_reg <= 1'b1;
                        end
                        if (!lo_found_reg)
                        begin
                            lo_reg       <= k_reg;
                            lo_found_reg <= 1'b1;
                        end
                    end
                    if (at_end)
                    begin
                        state_reg <= ST_SPAWN;
                    end
                end
                ST_SPAWN:
                begin
                    if (k_reg == '0)
                    begin
                        sel_reg   <= sel_next;
                        start_reg <= sel_next;
                    end
                    if (head_ctrl.load)
                    begin
                        pend_valid_reg <= 1'b1;
                    end
                    if (at_end)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_TICK:
                begin
                    if (at_end)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_DRAW:
                begin
                    if (shift && head_live)
                    begin
                        pend_valid_reg <= 1'b1;
                    end
                    if (shift && at_end)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // the hold-back slot is always drained before a new item is taken
    `PPU_ASSERT_NEVER(a_idle_pend_empty, s_axis_tready && pend_valid_reg)
    // only the final transfer of an item may carry no particle
    `PPU_ASSERT_IMPL(a_mid_draw_valid, (out_valid_reg && !out_last_reg) |-> out_data_reg[78])
    // the chosen spawn slot lies inside the pool
    `PPU_ASSERT_NEVER(a_sel_range, (state_reg == ST_SPAWN) && (32'(sel_reg) >= SLOTS))
endmodule
`default_nettype wire
